// ===== sv/rcv_pkg.sv =====
// shared types, constants and helper functions for the radix converter
`timescale 1ns / 1ps

package rcv_pkg;

    localparam int MAX_OUT_DIGITS_DEF = 64;
    localparam int VALUE_WIDTH_DEF    = 64;
    localparam int DIV_BITS           = 8;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_INDEX_W        = 2;
    localparam int BASE_W             = 6;
    localparam int CHAR_W             = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BASE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_BASE = CFG_INDEX_W'(1);

    localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] TARGET_BASE_RESET = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MIN          = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX          = BASE_W'(36);
    localparam logic [BASE_W-1:0] DIGIT_NINE        = BASE_W'(9);
    localparam logic [BASE_W-1:0] DIGIT_TEN         = BASE_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;

    typedef enum logic [1:0] {
        KIND_ECHO,
        KIND_DIGIT,
        KIND_BAD
    } rcv_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINAL,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } rcv_state_t;

    typedef struct packed {
        logic [BASE_W-1:0] source;
        logic [BASE_W-1:0] target;
    } rcv_bases_t;

    typedef struct packed {
        rcv_kind_t         kind;
        logic [BASE_W-1:0] dval;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } rcv_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rcv_q_status_t;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] val;
    } rcv_digit_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        return r;
    endfunction

    function automatic rcv_digit_t char_value(input logic [CHAR_W-1:0] c);
        rcv_digit_t        d;
        logic [CHAR_W-1:0] diff;
        d.ok  = 1'b0;
        d.val = '0;
        diff  = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff  = c - CHAR_ZERO;
            d.ok  = 1'b1;
            d.val = diff[BASE_W-1:0];
        end else if (c >= CHAR_A && c <= CHAR_Z) begin
            diff  = c - CHAR_A + {2'b00, DIGIT_TEN};
            d.ok  = 1'b1;
            d.val = diff[BASE_W-1:0];
        end
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] value_char(input logic [BASE_W-1:0] v);
        logic [CHAR_W-1:0] c;
        if (v <= DIGIT_NINE)
            c = CHAR_ZERO + {2'b00, v};
        else
            c = CHAR_A + {2'b00, v} - {2'b00, DIGIT_TEN};
        return c;
    endfunction

endpackage

// ===== sv/rcv_front.sv =====
// front end: takes input requests and classifies each character
`timescale 1ns / 1ps

module rcv_front
    import rcv_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] digit_char,
    input  logic              last_digit,
    input  rcv_bases_t        bases,
    input  rcv_q_status_t     q_status,
    output logic              q_push,
    output rcv_entry_t        q_entry
);

    rcv_digit_t digit;

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full;

    always_comb
    begin
        digit        = char_value(digit_char);
        q_entry.chr  = digit_char;
        q_entry.last = last_digit;
        q_entry.dval = digit.val;
        // equal bases pass every character through untouched
        if (bases.source == bases.target)
            q_entry.kind = KIND_ECHO;
        else if (digit.ok && digit.val < bases.source)
            q_entry.kind = KIND_DIGIT;
        else
            q_entry.kind = KIND_BAD;
    end

endmodule

// ===== sv/rcv_queue.sv =====
// short queue of classified characters between front and back end
`timescale 1ns / 1ps

module rcv_queue
    import rcv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcv_entry_t    push_entry,
    input  logic          pop,
    output rcv_entry_t    head,
    output rcv_q_status_t status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rcv_entry_t      entries [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/rcv_back.sv =====
// back end: accumulation, digit split by iterative division, digit stack and output register
`timescale 1ns / 1ps

module rcv_back
    import rcv_pkg::*;
#(
    parameter int MAX_OUT_DIGITS = MAX_OUT_DIGITS_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rcv_bases_t        bases,
    input  rcv_entry_t        head,
    input  rcv_q_status_t     q_status,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              last_char,
    output logic              error_flag
);

    localparam int NSTEP = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PADW  = NSTEP * DIV_BITS;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int AW    = $clog2(MAX_OUT_DIGITS);
    localparam int CW    = $clog2(MAX_OUT_DIGITS + 1);
    localparam int PRW   = VALUE_WIDTH + BASE_W + 1;

    rcv_state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  acc_reg, acc_next;
    logic                    bad_reg, bad_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [SW-1:0]           step_reg, step_next;
    logic [PADW-1:0]         q_reg, q_next;
    logic [BASE_W-1:0]       rem_reg, rem_next;
    logic [BASE_W-1:0]       rd_reg;
    logic [BASE_W-1:0]       stack [MAX_OUT_DIGITS];

    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    last_char_reg, last_char_next;
    logic                    error_flag_reg, error_flag_next;
    logic                    out_load, out_free;

    logic                    mem_we, mem_re;
    logic [CW-1:0]           cnt_m1;
    logic [PRW-1:0]          prod;
    logic                    ovf;
    logic [PADW-1:0]         q_step;
    logic [BASE_W-1:0]       r_step;
    logic [BASE_W:0]         trial;

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;
    assign error_flag = error_flag_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cnt_m1     = cnt_reg - 1'b1;

    // one multiply-add per digit, overflow when anything spills past the value width
    assign prod = PRW'(acc_reg) * PRW'(bases.source) + PRW'(head.dval);
    assign ovf  = |prod[PRW-1:VALUE_WIDTH];

    // restoring division by the target base, DIV_BITS quotient bits per cycle
    always_comb
    begin
        q_step = q_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial  = {r_step, q_step[PADW-1]};
            q_step = {q_step[PADW-2:0], 1'b0};
            if (trial >= {1'b0, bases.target})
            begin
                trial     = trial - {1'b0, bases.target};
                q_step[0] = 1'b1;
            end
            r_step = trial[BASE_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        bad_next        = bad_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        out_char_next   = out_char_reg;
        last_char_next  = last_char_reg;
        error_flag_next = error_flag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    unique case (head.kind)
                        KIND_ECHO:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                out_load        = 1'b1;
                                out_char_next   = head.chr;
                                last_char_next  = head.last;
                                error_flag_next = 1'b0;
                                if (head.last)
                                begin
                                    acc_next = '0;
                                    bad_next = 1'b0;
                                end
                            end
                        end
                        KIND_DIGIT:
                        begin
                            q_pop = 1'b1;
                            // accumulator freezes once the number is known bad
                            if (!bad_reg)
                            begin
                                if (ovf)
                                    bad_next = 1'b1;
                                else
                                    acc_next = prod[VALUE_WIDTH-1:0];
                            end
                            if (head.last)
                                state_next = ST_FINAL;
                        end
                        KIND_BAD:
                        begin
                            q_pop    = 1'b1;
                            bad_next = 1'b1;
                            if (head.last)
                                state_next = ST_FINAL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FINAL:
            begin
                if (bad_reg)
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_char_next   = '0;
                        last_char_next  = 1'b1;
                        error_flag_next = 1'b1;
                        acc_next        = '0;
                        bad_next        = 1'b0;
                        cnt_next        = '0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    q_next     = PADW'(acc_reg);
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                q_next = q_step;
                if (step_reg == SW'(NSTEP - 1))
                begin
                    mem_we    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (q_step == '0)
                        state_next = ST_READ;
                    else if (cnt_reg == CW'(MAX_OUT_DIGITS - 1))
                    begin
                        // more digits than the stack holds
                        bad_next   = 1'b1;
                        state_next = ST_FINAL;
                    end
                end
                else
                begin
                    rem_next  = r_step;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                cnt_next   = cnt_m1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_char_next   = value_char(rd_reg);
                    last_char_next  = (cnt_reg == '0);
                    error_flag_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        acc_next   = '0;
                        bad_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (out_load)
        begin
            out_char_reg   <= out_char_next;
            last_char_reg  <= last_char_next;
            error_flag_reg <= error_flag_next;
        end
    end

    // digit stack, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack[cnt_reg[AW-1:0]] <= r_step;
        if (mem_re)
            rd_reg <= stack[cnt_m1[AW-1:0]];
    end

endmodule

// ===== sv/radix_converter.sv =====
// radix converter top level: config registers, front end, queue and back end
// an accepted character is written into the queue and popped from there by the back end
// the multiply-add takes one character per cycle while the back end is idle and not stalled;
//   a final digit is then split by iterative division, one output digit per pass, and each
//   character is emitted through the digit stack read port in a read and an emit state
// reset: asynchronous active low; bases return to 10 and 2, no clearing pass, stack unset
`timescale 1ns / 1ps

module radix_converter
    import rcv_pkg::*;
#(
    parameter int MAX_OUT_DIGITS = MAX_OUT_DIGITS_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CHAR_W-1:0]      digit_char,
    input  logic                   last_digit,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   last_char,
    output logic                   error_flag,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]      cfg_data
);

    logic [BASE_W-1:0] source_base_reg, source_base_next;
    logic [BASE_W-1:0] target_base_reg, target_base_next;
    rcv_bases_t        bases;
    rcv_q_status_t     q_status;
    rcv_entry_t        q_entry;
    rcv_entry_t        q_head;
    logic              q_push;
    logic              q_pop;

    assign cfg_ready     = 1'b1;
    assign bases.source  = clamp_base(source_base_reg);
    assign bases.target  = clamp_base(target_base_reg);

    always_comb
    begin
        source_base_next = source_base_reg;
        target_base_next = target_base_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SOURCE_BASE)
                source_base_next = cfg_data;
            else if (cfg_index == REG_TARGET_BASE)
                target_base_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg <= SOURCE_BASE_RESET;
            target_base_reg <= TARGET_BASE_RESET;
        end
        else
        begin
            source_base_reg <= source_base_next;
            target_base_reg <= target_base_next;
        end
    end

    rcv_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .bases      (bases),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    rcv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    rcv_back #(
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bases      (bases),
        .head       (q_head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_char  (last_char),
        .error_flag (error_flag)
    );

`ifndef NO_ASSERTIONS
    // an error result is a lone zero character that closes the number
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> out_char == '0 && last_char)
        else $error("error result with nonzero character or open number");

    // back end never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("queue popped while empty");

    // converted characters are always digit characters
    a_digit_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error_flag && bases.source != bases.target |->
        (out_char >= CHAR_ZERO && out_char <= CHAR_NINE) ||
        (out_char >= CHAR_A && out_char <= CHAR_Z))
        else $error("converted character is not a digit");
`endif

endmodule

// ===== test/radix_converter_tb.sv =====
// testbench for radix_converter: directed table, random numbers, typed or predicted results
`timescale 1ns / 1ps

module radix_converter_tb;
    import rcv_pkg::*;

    localparam int  IDLE_PCT     = 18;
    localparam int  RAND_ITEMS   = 150;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  SETTLE       = 40;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  OUT_DIGITS   = MAX_OUT_DIGITS_DEF;
    localparam int  HOLD_PHASE   = 1;
    localparam int  CALM_PHASE   = 3;
    localparam int  PAUSE_PHASE  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
    localparam logic [63:0] VALUE_MAX = {VALUE_WIDTH_DEF{1'b1}};
    localparam bit  TYPED   = 1'b1;
    localparam bit  PREDICT = 1'b0;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              last;
        logic              err;
    } char_result_t;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              last;
        logic              typed;
        char_result_t      want;
    } digit_item_t;

    typedef struct packed {
        logic [BASE_W-1:0] src;
        logic [BASE_W-1:0] tgt;
        digit_item_t       item;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        // reset bases, decimal to binary
        '{6'd10, 6'd2, '{"0", 1'b1, TYPED, '{"0", 1'b1, 1'b0}}},
        '{6'd10, 6'd2, '{"5", 1'b1, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd10, 6'd2, '{"A", 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        '{6'd10, 6'd2, '{"1", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd10, 6'd2, '{"8", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd10, 6'd2, '{"4", 1'b1, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd10, 6'd2, '{8'h00, 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        '{6'd10, 6'd2, '{8'hFF, 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        // both bases clamp to 36: echo
        '{6'd63, 6'd37, '{8'h00, 1'b0, TYPED, '{8'h00, 1'b0, 1'b0}}},
        '{6'd63, 6'd37, '{8'hFF, 1'b1, TYPED, '{8'hFF, 1'b1, 1'b0}}},
        // both bases clamp to 2: echo
        '{6'd0, 6'd1, '{"Z", 1'b1, TYPED, '{"Z", 1'b1, 1'b0}}},
        '{6'd0, 6'd1, '{8'h80, 1'b1, TYPED, '{8'h80, 1'b1, 1'b0}}},
        '{6'd36, 6'd10, '{"Z", 1'b1, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd36, 6'd10, '{8'h7A, 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        '{6'd36, 6'd10, '{8'h40, 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        // bad digit in the middle poisons the whole number
        '{6'd2, 6'd36, '{"1", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"2", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"1", 1'b1, TYPED, '{8'h00, 1'b1, 1'b1}}},
        '{6'd2, 6'd36, '{"1", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"0", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"0", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"0", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"1", 1'b0, PREDICT, '{8'h00, 1'b0, 1'b0}}},
        '{6'd2, 6'd36, '{"1", 1'b1, PREDICT, '{8'h00, 1'b0, 1'b0}}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CHAR_W-1:0]      digit_char = '0;
    logic                   last_digit = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CHAR_W-1:0]      out_char;
    logic                   last_char;
    logic                   error_flag;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BASE_W-1:0]      cfg_data = '0;

    radix_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_char  (last_char),
        .error_flag (error_flag),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor state
    logic [BASE_W-1:0] src_base_reg = SOURCE_BASE_RESET;
    logic [BASE_W-1:0] tgt_base_reg = TARGET_BASE_RESET;
    logic [63:0]       acc_value = '0;
    logic              acc_bad = 1'b0;

    digit_item_t  digit_feed[$];
    char_result_t expected_chars[$];
    char_result_t converted[$];

    int  idle_pct = IDLE_PCT;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  rand_items = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("radix_converter_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [BASE_W-1:0] limit_base(input logic [BASE_W-1:0] b);
        if (b < 6'd2)
            return 6'd2;
        if (b > 6'd36)
            return 6'd36;
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [BASE_W-1:0] v);
        if (v <= DIGIT_NINE)
            return CHAR_ZERO + CHAR_W'(v);
        return CHAR_A + CHAR_W'(v) - CHAR_W'(DIGIT_TEN);
    endfunction

    // fold one character into the number; fills converted with what it causes
    function automatic void convert_digit(input logic [CHAR_W-1:0] chr, input logic last);
        logic [BASE_W-1:0] sb;
        logic [BASE_W-1:0] tb;
        logic [BASE_W-1:0] dv;
        logic              ok;
        logic [63:0]       v;
        logic [BASE_W-1:0] digs [0:63];
        int                n;
        sb = limit_base(src_base_reg);
        tb = limit_base(tgt_base_reg);
        converted.delete();
        if (sb == tb)
        begin
            converted.push_back('{chr, last, 1'b0});
            if (last)
            begin
                acc_value = '0;
                acc_bad = 1'b0;
            end
            return;
        end
        ok = 1'b1;
        dv = '0;
        if (chr >= CHAR_ZERO && chr <= CHAR_NINE)
            dv = BASE_W'(chr - CHAR_ZERO);
        else if (chr >= CHAR_A && chr <= CHAR_Z)
            dv = BASE_W'(chr - CHAR_A) + DIGIT_TEN;
        else
            ok = 1'b0;
        if (!ok || dv >= sb)
            acc_bad = 1'b1;
        else if (!acc_bad)
        begin
            if (acc_value > (VALUE_MAX - 64'(dv)) / 64'(sb))
                acc_bad = 1'b1;
            else
                acc_value = acc_value * 64'(sb) + 64'(dv);
        end
        if (!last)
            return;
        n = 0;
        if (!acc_bad)
        begin
            v = acc_value;
            do
            begin
                if (n >= OUT_DIGITS)
                begin
                    acc_bad = 1'b1;
                    break;
                end
                digs[n] = BASE_W'(v % 64'(tb));
                n++;
                v = v / 64'(tb);
            end while (v != 0);
        end
        if (acc_bad)
            converted.push_back('{8'h00, 1'b1, 1'b1});
        else
            for (int i = n - 1; i >= 0; i--)
                converted.push_back('{glyph(digs[i]), i == 0, 1'b0});
        acc_value = '0;
        acc_bad = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
        fail_count++;
    endtask

    // sender: offers requests from digit_feed, predicts on acceptance
    always @(posedge clk)
    begin
        digit_item_t cur;
        logic        go;
        if (rst_n)
        begin
            go = !in_valid;
            if (in_valid && !in_stall)
            begin
                cur = digit_feed.pop_front();
                convert_digit(cur.chr, cur.last);
                if (cur.typed)
                    expected_chars.push_back(cur.want);
                else
                    foreach (converted[i])
                        expected_chars.push_back(converted[i]);
                go = 1'b1;
            end
            if (go)
            begin
                if (digit_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    digit_char <= digit_feed[0].chr;
                    last_digit <= digit_feed[0].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, long hold-off on request, checks every result
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected result", out_char, 8'h00);
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.chr)
                        report_mismatch("out_char", out_char, want.chr);
                    if (last_char !== want.last)
                        report_mismatch("last_char", 8'(last_char), 8'(want.last));
                    if (error_flag !== want.err)
                        report_mismatch("error_flag", 8'(error_flag), 8'(want.err));
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BASE_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SOURCE_BASE)
            src_base_reg = data;
        else if (idx == REG_TARGET_BASE)
            tgt_base_reg = data;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (digit_feed.size() != 0 || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        wait_results();
        // non-final digits may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd2;
            3: return 6'd36;
            4: return 6'd37;
            5: return 6'd63;
            default: return BASE_W'($urandom_range(2, 36));
        endcase
    endfunction

    // queue one number: echo noise, or a digit string in radix sb
    task automatic add_number(input logic [BASE_W-1:0] sb, input bit echo);
        logic [CHAR_W-1:0] chars[$];
        logic [63:0]       v;
        int                kind;
        int                w;
        int                len;
        int                p;
        kind = $urandom_range(0, 99);
        if (echo)
        begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++)
                chars.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            if (sb >= 6'd10 && kind < 14)
                v = VALUE_MAX;
            else
            begin
                w = (sb >= 6'd10 && kind < 24) ? 64 : $urandom_range(0, (sb < 6'd8) ? 16 : 24);
                v = (w == 0) ? 64'd0 : ({$urandom, $urandom} >> (64 - w));
            end
            do
            begin
                chars.push_front(glyph(BASE_W'(v % 64'(sb))));
                v = v / 64'(sb);
            end while (v != 0);
            // the largest value times sb, past the value width
            if (sb >= 6'd10 && kind >= 8 && kind < 14)
                chars.push_back(CHAR_ZERO);
            if (kind % 7 == 0)
                repeat ($urandom_range(1, 2)) chars.push_front(CHAR_ZERO);
            if (kind >= 86)
            begin
                p = $urandom_range(0, chars.size() - 1);
                if (kind >= 93 && sb < 6'd36)
                    chars[p] = glyph(BASE_W'($urandom_range(sb, 35)));
                else
                    chars[p] = CHAR_W'($urandom_range(0, 255));
            end
        end
        foreach (chars[j])
            digit_feed.push_back('{chars[j], j == chars.size() - 1, PREDICT, '0});
        rand_items += chars.size();
    endtask

    initial
    begin
        logic [BASE_W-1:0] cur_src;
        logic [BASE_W-1:0] cur_tgt;
        logic [BASE_W-1:0] new_src;
        logic [BASE_W-1:0] new_tgt;
        int                phase;
        int                n_nums;
        bit                echo;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        cur_src = SOURCE_BASE_RESET;
        cur_tgt = TARGET_BASE_RESET;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].src != cur_src || DIR_TAB[i].tgt != cur_tgt)
            begin
                drain();
                if (DIR_TAB[i].src != cur_src)
                    write_reg(REG_SOURCE_BASE, DIR_TAB[i].src);
                if (DIR_TAB[i].tgt != cur_tgt)
                    write_reg(REG_TARGET_BASE, DIR_TAB[i].tgt);
                cur_src = DIR_TAB[i].src;
                cur_tgt = DIR_TAB[i].tgt;
            end
            digit_feed.push_back(DIR_TAB[i].item);
        end
        drain();
        // no such register: must leave both bases alone
        write_reg(REG_UNUSED, 6'h2A);
        digit_feed.push_back('{"1", 1'b1, PREDICT, '0});
        drain();

        phase = 0;
        while (rand_items < RAND_ITEMS || phase <= PAUSE_PHASE)
        begin
            new_src = pick_base();
            new_tgt = ($urandom_range(0, 5) == 0) ? new_src : pick_base();
            write_reg(REG_SOURCE_BASE, new_src);
            write_reg(REG_TARGET_BASE, new_tgt);
            echo = (limit_base(new_src) == limit_base(new_tgt));
            idle_pct = (phase == CALM_PHASE) ? 0 : IDLE_PCT;
            n_nums = (phase == CALM_PHASE || phase == HOLD_PHASE) ? 4 : $urandom_range(2, 4);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            for (int k = 0; k < n_nums; k++)
            begin
                if (phase == PAUSE_PHASE && k == n_nums / 2)
                    wait_results();
                add_number(limit_base(new_src), echo);
            end
            drain();
            phase++;
        end
        idle_pct = IDLE_PCT;

        drain();
        if (fail_count == 0)
            $display("radix_converter_tb OK");
        else
            $display("radix_converter_tb NOT OK");
        $finish;
    end

endmodule
